>>> design/bfa_pkg.sv
// bfa_pkg: shared constants and types for the bitmap frame allocator
// bitmap geometry, operation codes, ram write port and bit unit result structs
// no dependencies
`default_nettype none

package bfa_pkg;

  localparam int BITMAP_BYTES = 4096;
  localparam int FRAME_BYTES  = 4096;
  localparam int BYTE_BITS    = 8;
  localparam int WORD_W       = 32;
  localparam int MEM_WORDS    = BITMAP_BYTES * BYTE_BITS / WORD_W;
  localparam int WADDR_W      = $clog2(MEM_WORDS);
  localparam int BIT_W        = $clog2(WORD_W);
  localparam int FRAME_W      = 15;
  localparam int ADDR_W       = 27;
  localparam int FRAME_SHIFT  = $clog2(FRAME_BYTES);

  localparam logic OP_ALLOCATE = 1'b0;
  localparam logic OP_RESERVE  = 1'b1;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [WADDR_W-1:0] waddr_t;
  typedef logic [BIT_W-1:0]   bitpos_t;

  typedef struct packed {
    logic   en;
    waddr_t addr;
    word_t  data;
  } ram_wr_t;

  typedef struct packed {
    logic    full;
    bitpos_t bit_pos;
    word_t   word;
  } bit_res_t;

endpackage

`default_nettype wire

>>> design/bfa_bitmap_ram.sv
// bfa_bitmap_ram: bitmap store, one write port and one registered read port
// depends on bfa_pkg
`default_nettype none

module bfa_bitmap_ram (
  input  wire                   clk,
  input  wire bfa_pkg::ram_wr_t wr,
  input  wire                   rd_en,
  input  wire bfa_pkg::waddr_t  rd_addr,
  output bfa_pkg::word_t        rd_data
);
  import bfa_pkg::*;

  word_t mem [MEM_WORDS];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> design/bfa_bit_unit.sv
// bfa_bit_unit: shared bit unit, finds the lowest clear bit or takes a given one
// and returns the bitmap word with that bit set; depends on bfa_pkg
`default_nettype none

module bfa_bit_unit (
  input  wire bfa_pkg::word_t   word,
  input  wire                   use_index,
  input  wire bfa_pkg::bitpos_t index,
  output bfa_pkg::bit_res_t     res
);
  import bfa_pkg::*;

  word_t   inv;
  word_t   lowest;
  bitpos_t pos;
  bitpos_t sel;

  always_comb begin
    inv    = ~word;
    lowest = inv & (~inv + WORD_W'(1));
    pos    = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (lowest[i]) begin
        pos = BIT_W'(i);
      end
    end
    sel         = use_index ? index : pos;
    res.full    = &word;
    res.bit_pos = sel;
    res.word    = word | (WORD_W'(1) << sel);
  end

endmodule

`default_nettype wire

>>> design/bitmap_frame_allocator.sv
// bitmap_frame_allocator: first-fit physical frame allocator over a 32k-bit bitmap
// reserve reads the addressed word and writes it back with the bit set; allocate scans
// up from word 0, one 32-bit bitmap word read per cycle through the single ram read port
// one transaction in flight; next accepted the cycle after the result is taken
// after reset a clearing pass writes zeros to all 1024 words, not ready
// depends on bfa_pkg, bfa_bitmap_ram, bfa_bit_unit
`default_nettype none

module bitmap_frame_allocator (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_operation,
  input  wire [bfa_pkg::FRAME_W-1:0]   in_frame_index,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [bfa_pkg::ADDR_W-1:0]   out_frame_address,
  output logic                         out_no_free
);
  import bfa_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RSV   = 2'd2;
  localparam logic [1:0] ST_SCAN  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  waddr_t            clr_r, clr_nxt;
  waddr_t            data_addr_r, data_addr_nxt;
  bitpos_t           bit_idx_r, bit_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic              out_nf_r, out_nf_nxt;

  ram_wr_t  wr;
  logic     rd_en;
  waddr_t   rd_addr;
  word_t    rd_data;
  bit_res_t res;
  logic     accept;

  bfa_bitmap_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bfa_bit_unit u_bit (
    .word      (rd_data),
    .use_index (state_r == ST_RSV),
    .index     (bit_idx_r),
    .res       (res)
  );

  assign in_ready          = (state_r == ST_IDLE) && !out_valid_r;
  assign accept            = in_valid && in_ready;
  assign out_valid         = out_valid_r;
  assign out_frame_address = out_addr_r;
  assign out_no_free       = out_nf_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    data_addr_nxt = data_addr_r;
    bit_idx_nxt   = bit_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_addr_nxt  = out_addr_r;
    out_nf_nxt    = out_nf_r;
    rd_en         = 1'b0;
    rd_addr       = data_addr_r;
    wr            = '0;
    case (state_r)
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_r;
        wr.data = '0;
        clr_nxt = clr_r + WADDR_W'(1);
        if (clr_r == WADDR_W'(MEM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          rd_en = 1'b1;
          if (in_operation == OP_RESERVE) begin
            rd_addr       = in_frame_index[FRAME_W-1:BIT_W];
            data_addr_nxt = in_frame_index[FRAME_W-1:BIT_W];
            bit_idx_nxt   = in_frame_index[BIT_W-1:0];
            state_nxt     = ST_RSV;
          end else begin
            rd_addr       = '0;
            data_addr_nxt = '0;
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_RSV: begin
        wr.en         = 1'b1;
        wr.addr       = data_addr_r;
        wr.data       = res.word;
        out_valid_nxt = 1'b1;
        out_addr_nxt  = {data_addr_r, bit_idx_r, {FRAME_SHIFT{1'b0}}};
        out_nf_nxt    = 1'b0;
        state_nxt     = ST_IDLE;
      end
      ST_SCAN: begin
        if (!res.full) begin
          wr.en         = 1'b1;
          wr.addr       = data_addr_r;
          wr.data       = res.word;
          out_valid_nxt = 1'b1;
          out_addr_nxt  = {data_addr_r, res.bit_pos, {FRAME_SHIFT{1'b0}}};
          out_nf_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (data_addr_r == WADDR_W'(MEM_WORDS - 1)) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_nf_nxt    = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = data_addr_r + WADDR_W'(1);
          data_addr_nxt = data_addr_r + WADDR_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_addr_r <= data_addr_nxt;
    bit_idx_r   <= bit_idx_nxt;
    out_addr_r  <= out_addr_nxt;
    out_nf_r    <= out_nf_nxt;
  end

`ifndef ASSERT_OFF
  a_clear_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("input ready during clearing pass");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second transaction accepted while one is in flight");

  a_reserve_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_RESERVE) |-> ##2 out_valid)
    else $error("reserve result not ready two cycles after accept");

  a_no_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_free) |-> (out_frame_address == '0))
    else $error("no-free result carries a nonzero address");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !wr.en)
    else $error("bitmap written while idle");
`endif

endmodule

`default_nettype wire
